// File: design/hte_pkg.sv
package hte_pkg;
  localparam int INDEX_BITS_DEF = 14;
  localparam int WAYS_DEF       = 3;
  localparam int ENTRY_W        = 64;
  localparam int EPOCH_W        = 8;
  localparam int AGE_W          = 5;

  localparam int SH_FROM  = 58;
  localparam int SH_TO    = 52;
  localparam int SH_PROMO = 48;
  localparam int SH_DEPTH = 40;
  localparam int SH_BOUND = 37;
  localparam int SH_AGE   = 32;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_STORE  = 2'd1,
    ACT_AGE    = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;
endpackage

// File: design/hte_ram.sv
module hte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a same-edge write is seen by the next read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// File: design/hashed_three_way_entry_table.sv
// Bucketed hash table of packed 64-bit entries, one request per item.
// Input channel (in_*): action, position hash and store payload; a request is
// taken when in_valid is high and in_stall is low. Result channel (out_*): one
// result per request, taken when out_valid is high and out_stall is low.
// A request reads the bucket RAM at accept, is resolved in the resolve stage and
// its result is then held in the output register.
// Throughput: one request per cycle for lookup, store and age tick while the
// receiver does not stall and no sweep runs; the bucket read-modify-write
// overlaps the next read, a same-bucket write is forwarded. A clear holds the
// input while it is in the resolve stage. Bucket validity uses an epoch tag
// stored with each bucket. Reset, and every clear that wraps the epoch counter,
// starts a sweep that rewrites all 2^INDEX_BITS buckets, one per cycle (16384
// buckets by default); in_stall is high during the sweep. Age resets to zero.
// When the receiver stalls, the result holds in the output register, the
// resolve stage holds behind it, and in_stall rises.
module hashed_three_way_entry_table
  import hte_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int WAYS       = WAYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_action,
  input  logic [63:0]           in_position_hash,
  input  logic [5:0]            in_move_from,
  input  logic [5:0]            in_move_to,
  input  logic [3:0]            in_promotion_code,
  input  logic [7:0]            in_search_depth,
  input  logic [2:0]            in_bound_kind,
  input  logic signed [31:0]    in_score_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [5:0]            out_found_from,
  output logic [5:0]            out_found_to,
  output logic [3:0]            out_found_promotion,
  output logic [7:0]            out_found_depth,
  output logic [2:0]            out_found_bound,
  output logic [4:0]            out_found_age,
  output logic signed [31:0]    out_found_score,
  output logic                  out_written
);
  localparam int SLOT_W = 2 * ENTRY_W;
  localparam int WORD_W = WAYS * SLOT_W + EPOCH_W;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [EPOCH_W-1:0] EPOCH_TOP = '1;

  // sweep and epoch state
  logic                  sweep_r;
  logic [INDEX_BITS-1:0] sweep_cnt_r;
  logic [EPOCH_W-1:0]    epoch_r;
  logic [AGE_W-1:0]      age_r;

  // resolve stage
  logic                  s1_valid_r;
  action_t               s1_action_r;
  logic [63:0]           s1_hash_r;
  logic [5:0]            s1_from_r, s1_to_r;
  logic [3:0]            s1_promo_r;
  logic [7:0]            s1_depth_r;
  logic [2:0]            s1_bound_r;
  logic [31:0]           s1_score_r;

  // forwarding of the last bucket write
  logic                  fwd_valid_r;
  logic [INDEX_BITS-1:0] fwd_bkt_r;
  logic [WORD_W-1:0]     fwd_word_r;

  logic                  in_accept, s1_adv;
  logic [WORD_W-1:0]     rd_word, cur_word, new_word;
  logic [INDEX_BITS-1:0] s1_bkt;
  logic                  bkt_ok;

  logic                  wr_en;
  logic [INDEX_BITS-1:0] wr_addr;
  logic [WORD_W-1:0]     wr_data;

  assign s1_bkt    = s1_hash_r[INDEX_BITS-1:0];
  assign s1_adv    = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall  = sweep_r || (s1_valid_r && (!s1_adv || s1_action_r == ACT_CLEAR));
  assign in_accept = in_valid && !in_stall;

  hte_ram #(
    .WIDTH(WORD_W),
    .DEPTH(2 ** INDEX_BITS)
  ) u_bucket_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (in_accept),
    .rd_addr(in_position_hash[INDEX_BITS-1:0]),
    .rd_data(rd_word)
  );

  // bucket as seen by the resolve stage: forwarded if the prior request wrote it
  assign cur_word = (fwd_valid_r && fwd_bkt_r == s1_bkt) ? fwd_word_r : rd_word;
  assign bkt_ok   = cur_word[WAYS*SLOT_W +: EPOCH_W] == epoch_r;

  logic [63:0] way_key  [WAYS];
  logic [63:0] way_dat  [WAYS];
  logic [63:0] packed_entry;
  logic        lk_found;
  logic [7:0]  lk_depth;
  logic [63:0] lk_best;
  logic        st_done, st_skip, st_hv;
  logic [WAY_W-1:0] st_way;
  logic [7:0]  st_least;
  logic        st_write;

  always_comb begin
    packed_entry = {s1_from_r, s1_to_r, s1_promo_r, s1_depth_r, s1_bound_r, age_r, s1_score_r};
    lk_found = 1'b0;
    lk_depth = '0;
    lk_best  = '0;
    st_done  = 1'b0;
    st_skip  = 1'b0;
    st_hv    = 1'b0;
    st_way   = '0;
    st_least = '0;
    for (int w = 0; w < WAYS; w++) begin
      way_key[w] = bkt_ok ? cur_word[w*SLOT_W +: ENTRY_W] : '0;
      way_dat[w] = bkt_ok ? cur_word[w*SLOT_W+ENTRY_W +: ENTRY_W] : '0;
    end
    for (int w = 0; w < WAYS; w++) begin
      // lookup: deepest match, first on ties
      if ((way_key[w] ^ way_dat[w]) == s1_hash_r &&
          (!lk_found || way_dat[w][SH_DEPTH +: 8] > lk_depth)) begin
        lk_found = 1'b1;
        lk_depth = way_dat[w][SH_DEPTH +: 8];
        lk_best  = way_dat[w];
      end
      // store: first match, else last empty way, else first shallowest way
      if (!st_done) begin
        if ((way_key[w] ^ way_dat[w]) == s1_hash_r) begin
          st_done = 1'b1;
          st_way  = WAY_W'(w);
          st_skip = (way_dat[w][SH_AGE +: AGE_W] == age_r) &&
                    (way_dat[w][SH_DEPTH +: 8] > s1_depth_r);
        end else begin
          if (way_key[w] == '0 && way_dat[w] == '0) begin
            st_way = WAY_W'(w);
          end
          if (!st_hv || way_dat[w][SH_DEPTH +: 8] < st_least) begin
            st_hv    = 1'b1;
            st_least = way_dat[w][SH_DEPTH +: 8];
            st_way   = WAY_W'(w);
          end
        end
      end
    end
    st_write = st_done ? !st_skip : st_hv;
    new_word = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == st_way) begin
        new_word[w*SLOT_W +: SLOT_W] = {packed_entry, packed_entry ^ s1_hash_r};
      end else begin
        new_word[w*SLOT_W +: SLOT_W] = {way_dat[w], way_key[w]};
      end
    end
    new_word[WAYS*SLOT_W +: EPOCH_W] = epoch_r;
  end

  logic store_wr;
  assign store_wr = s1_adv && s1_action_r == ACT_STORE && st_write;

  // sweep owns the write port; no request is in flight then
  always_comb begin
    if (sweep_r) begin
      wr_en   = 1'b1;
      wr_addr = sweep_cnt_r;
      wr_data = '0;
    end else begin
      wr_en   = store_wr;
      wr_addr = s1_bkt;
      wr_data = new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
      epoch_r     <= {{(EPOCH_W-1){1'b0}}, 1'b1};
      age_r       <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (sweep_r) begin
        sweep_cnt_r <= sweep_cnt_r + 1'b1;
        if (sweep_cnt_r == '1) begin
          sweep_r <= 1'b0;
        end
      end
      if (s1_adv) begin
        fwd_valid_r <= store_wr;
        unique case (s1_action_r)
          ACT_AGE: begin
            age_r <= age_r + 1'b1;
          end
          ACT_CLEAR: begin
            age_r <= '0;
            // bump the epoch; on wrap, rewrite every bucket
            if (epoch_r == EPOCH_TOP) begin
              epoch_r     <= {{(EPOCH_W-1){1'b0}}, 1'b1};
              sweep_r     <= 1'b1;
              sweep_cnt_r <= '0;
            end else begin
              epoch_r <= epoch_r + 1'b1;
            end
          end
          ACT_LOOKUP, ACT_STORE: begin
          end
        endcase
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r <= action_t'(in_action);
      s1_hash_r   <= in_position_hash;
      s1_from_r   <= in_move_from;
      s1_to_r     <= in_move_to;
      s1_promo_r  <= in_promotion_code;
      s1_depth_r  <= in_search_depth;
      s1_bound_r  <= in_bound_kind;
      s1_score_r  <= in_score_value;
    end
    if (s1_adv) begin
      fwd_bkt_r  <= s1_bkt;
      fwd_word_r <= new_word;
      if (s1_action_r == ACT_LOOKUP && lk_best != '0) begin
        out_hit             <= 1'b1;
        out_found_from      <= lk_best[SH_FROM +: 6];
        out_found_to        <= lk_best[SH_TO +: 6];
        out_found_promotion <= lk_best[SH_PROMO +: 4];
        out_found_depth     <= lk_best[SH_DEPTH +: 8];
        out_found_bound     <= lk_best[SH_BOUND +: 3];
        out_found_age       <= lk_best[SH_AGE +: AGE_W];
        out_found_score     <= lk_best[31:0];
      end else begin
        out_hit             <= 1'b0;
        out_found_from      <= '0;
        out_found_to        <= '0;
        out_found_promotion <= '0;
        out_found_depth     <= '0;
        out_found_bound     <= '0;
        out_found_age       <= '0;
        out_found_score     <= '0;
      end
      out_written <= store_wr;
    end
  end
endmodule

// File: design/hte_checker.sv
module hte_checker
  import hte_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_hit,
  input logic [7:0]        out_found_depth,
  input logic signed [31:0] out_found_score,
  input logic              out_written
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) && $stable(out_written))
    else $error("stalled result changed");

  // a result is never both a lookup hit and a store write
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_written))
    else $error("hit and written together");

  // a miss carries zero depth and score
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_found_depth == 8'd0 && out_found_score == 32'sd0)
    else $error("miss with nonzero fields");

  // no result right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind hashed_three_way_entry_table hte_checker u_hte_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hit        (out_hit),
  .out_found_depth(out_found_depth),
  .out_found_score(out_found_score),
  .out_written    (out_written)
);

// File: dv/hashed_three_way_entry_table_tb.sv
module hashed_three_way_entry_table_tb;
  import hte_pkg::*;

  localparam int NBKT = 1 << INDEX_BITS_DEF;
  localparam int NW   = WAYS_DEF;

  typedef struct packed {
    logic        hit;
    logic [5:0]  from_sq;
    logic [5:0]  to_sq;
    logic [3:0]  promo;
    logic [7:0]  depth;
    logic [2:0]  bound;
    logic [4:0]  age;
    logic [31:0] score;
    logic        written;
  } probe_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_action;
  logic [63:0] in_position_hash;
  logic [5:0] in_move_from;
  logic [5:0] in_move_to;
  logic [3:0] in_promotion_code;
  logic [7:0] in_search_depth;
  logic [2:0] in_bound_kind;
  logic signed [31:0] in_score_value;
  logic out_valid;
  logic out_stall;
  logic out_hit;
  logic [5:0] out_found_from;
  logic [5:0] out_found_to;
  logic [3:0] out_found_promotion;
  logic [7:0] out_found_depth;
  logic [2:0] out_found_bound;
  logic [4:0] out_found_age;
  logic signed [31:0] out_found_score;
  logic out_written;

  hashed_three_way_entry_table u_dut (.*);

  // Shadow of the table: sparse per-bucket ways plus a validity bit.
  logic [63:0] shadow_key [int];
  logic [63:0] shadow_data [int];
  bit          shadow_valid [int];
  logic [4:0]  table_age;

  probe_result_t expected_results [$];
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  logic [63:0] hash_pool [$];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #80000000;
    $display("hashed_three_way_entry_table: mismatch");
    $finish;
  end

  function automatic void read_way(int bkt, int w, output logic [63:0] k,
                                   output logic [63:0] d);
    if (!shadow_valid.exists(bkt) || !shadow_valid[bkt]) begin
      k = '0;
      d = '0;
    end else begin
      k = shadow_key[bkt*NW + w];
      d = shadow_data[bkt*NW + w];
    end
  endfunction

  function automatic void write_way(int bkt, int w, logic [63:0] d, logic [63:0] h);
    if (!shadow_valid.exists(bkt) || !shadow_valid[bkt]) begin
      for (int i = 0; i < NW; i++) begin
        shadow_key[bkt*NW + i] = '0;
        shadow_data[bkt*NW + i] = '0;
      end
      shadow_valid[bkt] = 1'b1;
    end
    shadow_data[bkt*NW + w] = d;
    shadow_key[bkt*NW + w] = d ^ h;
  endfunction

  // Apply one request to the shadow table and return the result it yields.
  function automatic probe_result_t resolve_probe(action_t act, logic [63:0] h,
      logic [5:0] fr, logic [5:0] to, logic [3:0] pr, logic [7:0] dep,
      logic [2:0] bd, logic [31:0] sc);
    probe_result_t r;
    int bkt;
    logic [63:0] k, d, best, packed_entry;
    logic [7:0] best_dep, least;
    bit found, have_victim;
    int victim;
    r = '0;
    bkt = int'(h[INDEX_BITS_DEF-1:0]);
    case (act)
      ACT_LOOKUP: begin
        found = 0;
        best = '0;
        best_dep = '0;
        for (int w = 0; w < NW; w++) begin
          read_way(bkt, w, k, d);
          if ((k ^ d) == h && (!found || d[SH_DEPTH +: 8] > best_dep)) begin
            found = 1;
            best_dep = d[SH_DEPTH +: 8];
            best = d;
          end
        end
        if (best != '0) begin
          r.hit = 1'b1;
          r.from_sq = best[SH_FROM +: 6];
          r.to_sq = best[SH_TO +: 6];
          r.promo = best[SH_PROMO +: 4];
          r.depth = best[SH_DEPTH +: 8];
          r.bound = best[SH_BOUND +: 3];
          r.age = best[SH_AGE +: 5];
          r.score = best[31:0];
        end
      end
      ACT_STORE: begin
        packed_entry = {fr, to, pr, dep, bd, table_age, sc};
        have_victim = 0;
        victim = 0;
        least = '0;
        for (int w = 0; w < NW; w++) begin
          read_way(bkt, w, k, d);
          if ((k ^ d) == h) begin
            // Keep a fresher, deeper entry; otherwise overwrite in place.
            if (!(d[SH_AGE +: 5] == table_age && d[SH_DEPTH +: 8] > dep)) begin
              write_way(bkt, w, packed_entry, h);
              r.written = 1'b1;
            end
            return r;
          end
          if (k == '0 && d == '0) victim = w;
          if (!have_victim || d[SH_DEPTH +: 8] < least) begin
            have_victim = 1;
            least = d[SH_DEPTH +: 8];
            victim = w;
          end
        end
        write_way(bkt, victim, packed_entry, h);
        r.written = 1'b1;
      end
      ACT_AGE: table_age = table_age + 5'd1;
      default: begin
        table_age = '0;
        shadow_valid.delete();
      end
    endcase
    return r;
  endfunction

  // Send one request; the expectation is queued at the accepting edge.
  task automatic send_probe(action_t act, logic [63:0] h, logic [7:0] dep = 8'd0,
                            bit rand_payload = 1);
    probe_result_t r;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_position_hash <= h;
    in_search_depth <= dep;
    if (rand_payload) begin
      in_move_from <= 6'($urandom);
      in_move_to <= 6'($urandom);
      in_promotion_code <= 4'($urandom);
      in_bound_kind <= 3'($urandom);
      in_score_value <= $urandom;
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = resolve_probe(act, h, in_move_from, in_move_to, in_promotion_code,
                      in_search_depth, in_bound_kind, in_score_value);
    expected_results.push_back(r);
    @(negedge clk);
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
  endtask

  // Receiver stall: random, plus a long hold-off when asked.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each accepted result against the oldest expectation.
  always @(posedge clk) begin
    probe_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_hit, out_found_from, out_found_to, out_found_promotion,
             out_found_depth, out_found_bound, out_found_age, out_found_score,
             out_written};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result differs: expected %h actual %h", want, got);
        end
      end
    end
  end

  function automatic logic [63:0] pick_hash();
    logic [63:0] h;
    if (hash_pool.size() > 0 && $urandom_range(99) < 70)
      return hash_pool[$urandom_range(hash_pool.size() - 1)];
    // Crowd a few buckets so ways collide and get evicted.
    h = {$urandom, $urandom};
    h[INDEX_BITS_DEF-1:0] = INDEX_BITS_DEF'($urandom_range(15));
    if (hash_pool.size() < 64) hash_pool.push_back(h);
    return h;
  endfunction

  task automatic test_directed();
    logic [63:0] h;
    h = 64'h0123_4567_89AB_0005;
    send_probe(ACT_LOOKUP, 64'd0);              // hash zero on an empty bucket
    send_probe(ACT_STORE, 64'd0, 8'd0);         // hash zero store
    send_probe(ACT_LOOKUP, 64'd0);
    send_probe(ACT_LOOKUP, '1);
    send_probe(ACT_STORE, h, 8'd10);
    send_probe(ACT_STORE, h, 8'd5);             // fresher and deeper: skipped
    send_probe(ACT_LOOKUP, h);
    send_probe(ACT_AGE, h);
    send_probe(ACT_STORE, h, 8'd1);             // older entry: overwritten
    send_probe(ACT_STORE, h ^ 64'h1_0000_0000, 8'd255);
    send_probe(ACT_STORE, h ^ 64'h2_0000_0000, 8'd0);
    send_probe(ACT_STORE, h ^ 64'h3_0000_0000, 8'd7); // full bucket: evict least
    send_probe(ACT_LOOKUP, h ^ 64'h1_0000_0000);
    send_probe(ACT_LOOKUP, h ^ 64'h3_0000_0000);
    send_probe(ACT_CLEAR, '1);
    // Zero data entry: matches but counts as a miss.
    in_move_from <= '0; in_move_to <= '0; in_promotion_code <= '0;
    in_bound_kind <= '0; in_score_value <= '0;
    send_probe(ACT_STORE, 64'h42, 8'd0, 0);
    send_probe(ACT_LOOKUP, 64'h42);
    send_probe(ACT_LOOKUP, 64'd0);
    send_probe(ACT_STORE, '1, 8'd255);
    send_probe(ACT_LOOKUP, '1);
    repeat (33) send_probe(ACT_AGE, 64'd0);     // wrap the age counter
    send_probe(ACT_CLEAR, 64'd0);
    send_probe(ACT_LOOKUP, h);
    drain_results();
  endtask

  task automatic test_random(int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 45) send_probe(ACT_LOOKUP, pick_hash());
      else if (roll < 93) send_probe(ACT_STORE, pick_hash(), 8'($urandom));
      else if (roll < 99) send_probe(ACT_AGE, {$urandom, $urandom});
      else send_probe(ACT_CLEAR, {$urandom, $urandom});
    end
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(450);
    send_idle_pct = 66; recv_stall_pct = 0;  test_random(450);
    send_idle_pct = 0;  recv_stall_pct = 66; test_random(450);
    send_idle_pct = 16; recv_stall_pct = 16; test_random(450);
    drain_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    hold_off_cycles <= 60;
    test_random(100);
    drain_results();
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_action = ACT_LOOKUP; in_position_hash = '0;
    in_move_from = '0; in_move_to = '0; in_promotion_code = '0;
    in_search_depth = '0; in_bound_kind = '0; in_score_value = '0;
    out_stall = 0; mismatches = 0; table_age = '0; hold_off_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_idle_phases();
    test_backpressure();
    if (mismatches == 0 && expected_results.size() == 0)
      $display("hashed_three_way_entry_table: match");
    else
      $display("hashed_three_way_entry_table: mismatch");
    $finish;
  end
endmodule

// File: sim.f
design/hte_pkg.sv
design/hte_ram.sv
design/hashed_three_way_entry_table.sv
design/hte_checker.sv
dv/hashed_three_way_entry_table_tb.sv
